@@ hw/rtl/double_hash_table_macros.svh @@
// Assertion helpers used by double_hash_table.sv.
`ifndef DOUBLE_HASH_TABLE_MACROS_SVH
`define DOUBLE_HASH_TABLE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define DHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dht_pkg.sv @@
package dht_pkg;

    localparam int KEY_W       = 31;
    localparam int WORD_W      = 32;
    // key padded with one leading zero so it splits into whole digits
    localparam int KEY_PAD_W   = 32;
    localparam int DIGIT_W     = 4;
    localparam int HASH_CYCLES = KEY_PAD_W / DIGIT_W;
    localparam int HASH_CNT_W  = $clog2(HASH_CYCLES);

    localparam int MOD7_W = 3;
    localparam logic [MOD7_W:0] STEP_BASE = 4'd7;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] word;
    } dht_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

endpackage

@@ hw/rtl/dht_mod_unit.sv @@
module dht_mod_unit #(
    parameter int SLOTS = 16,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [dht_pkg::KEY_W-1:0] key,
    output logic [IDX_W-1:0]          home,
    output logic [dht_pkg::MOD7_W-1:0] key_mod7,
    output dht_pkg::mod_status_t      stat
);
    import dht_pkg::*;

    logic [KEY_PAD_W-1:0]  shift_reg;
    logic [IDX_W-1:0]      rem_s_reg, rem_s_next;
    logic [MOD7_W-1:0]     rem_7_reg, rem_7_next;
    logic [HASH_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Shift in one digit: restoring remainder step for both moduli per bit
    always_comb begin
        logic [IDX_W:0]  ts;
        logic [MOD7_W:0] t7;
        logic [IDX_W-1:0]  rs;
        logic [MOD7_W-1:0] r7;
        rs = rem_s_reg;
        r7 = rem_7_reg;
        for (int d = 0; d < DIGIT_W; d++) begin
            ts = {rs, shift_reg[KEY_PAD_W-1-d]};
            if (ts >= (IDX_W+1)'(SLOTS)) begin
                ts = ts - (IDX_W+1)'(SLOTS);
            end
            rs = ts[IDX_W-1:0];
            t7 = {r7, shift_reg[KEY_PAD_W-1-d]};
            if (t7 >= STEP_BASE) begin
                t7 = t7 - STEP_BASE;
            end
            r7 = t7[MOD7_W-1:0];
        end
        rem_s_next = rs;
        rem_7_next = r7;
    end

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == HASH_CNT_W'(HASH_CYCLES-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load key, then advance one digit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= {1'b0, key};
            rem_s_reg <= '0;
            rem_7_reg <= '0;
        end else if (busy_reg) begin
            shift_reg <= shift_reg << DIGIT_W;
            rem_s_reg <= rem_s_next;
            rem_7_reg <= rem_7_next;
        end
    end

    assign home      = rem_s_reg;
    assign key_mod7  = rem_7_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/dht_slot_ram.sv @@
module dht_slot_ram #(
    parameter int SLOTS = 16,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  dht_pkg::dht_entry_t wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output dht_pkg::dht_entry_t rd_data
);
    import dht_pkg::*;

    dht_entry_t mem [SLOTS];
    dht_entry_t rd_data_reg;

    // One write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/double_hash_table.sv @@
// Open-addressing hash table with double hashing over SLOTS entries. Each input transaction
// carries an insert (tuser 0) or a lookup (tuser 1); each yields exactly one result
// transaction with a status in tuser and the found word in tdata. The home slot is
// key mod SLOTS and the probe step is 7 - (key mod 7); both remainders come from one shared
// remainder unit that consumes four key bits per cycle over the padded key. Hashing starts
// the unit, lets it run through all digits, and collects the remainders when it is done.
// Probing then reads the slot memory through its single read port, one slot per cycle, for
// at most SLOTS probes. The result sits in an output register, so the next item is accepted
// in the cycle after the result is loaded; the block takes no new item before the last one's
// result is loaded. Only if the previous result is still waiting when a probe ends does the
// probe hold until that result transaction completes. After reset the block runs a clearing
// pass over every slot of the slot memory and holds s_tready low until it is done.
module double_hash_table #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [30:0] key, [62:31] data_word, [63] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] found_word
    output logic [1:0]  m_tuser    // [1:0] status
);
    import dht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    state_t            state_reg, state_next;
    opcode_t           op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [WORD_W-1:0] word_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  stepr_reg, stepr_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    logic              in_fire;
    logic              out_free;
    logic              res_load;
    logic              mod_start;
    logic [IDX_W-1:0]  home;
    logic [MOD7_W-1:0] key_mod7;
    mod_status_t       mod_stat;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    dht_entry_t        wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    dht_entry_t        rd_data;

    logic              hit;
    logic [IDX_W-1:0]  idx_adv;

    // Reduce a step of 1..7 into 0..SLOTS-1
    function automatic logic [IDX_W-1:0] step_mod(input logic [MOD7_W-1:0] kmod7);
        logic [31:0] s;
        s = 32'(STEP_BASE) - 32'(kmod7);
        for (int k = 0; k < 3; k++) begin
            if (s >= 32'(SLOTS)) begin
                s = s - 32'(SLOTS);
            end
        end
        return IDX_W'(s);
    endfunction

    dht_mod_unit #(.SLOTS(SLOTS)) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .key      (key_reg),
        .home     (home),
        .key_mod7 (key_mod7),
        .stat     (mod_stat)
    );

    dht_slot_ram #(.SLOTS(SLOTS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_fire  = s_tvalid && s_tready;
    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || m_tready;

    // Next probe slot: index plus reduced step, wrapped once
    always_comb begin
        logic [IDX_W:0] sum;
        sum = {1'b0, idx_reg} + {1'b0, stepr_reg};
        if (sum >= (IDX_W+1)'(SLOTS)) begin
            sum = sum - (IDX_W+1)'(SLOTS);
        end
        idx_adv = sum[IDX_W-1:0];
    end

    // Probe stops at an empty slot or a matching key
    assign hit = !rd_data.valid || (rd_data.key == key_reg);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        stepr_next  = stepr_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        found_next  = found_reg;
        s_tready    = 1'b0;
        mod_start   = 1'b0;
        res_load    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '{valid: 1'b1, key: key_reg, word: word_reg};
        rd_en       = 1'b0;
        rd_addr     = idx_adv;
        unique case (state_reg)
            S_CLEAR: begin
                // sweep the memory, marking every slot empty
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(SLOTS-1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                mod_start = !mod_stat.busy && !mod_stat.done && (cnt_reg == '1);
                if (mod_stat.done) begin
                    // issue the read of the home slot
                    rd_en      = 1'b1;
                    rd_addr    = home;
                    idx_next   = home;
                    stepr_next = step_mod(key_mod7);
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end else if (!mod_stat.busy) begin
                    mod_start = 1'b1;
                end
            end
            S_PROBE: begin
                // read ahead at the next slot while checking this one
                rd_en = 1'b1;
                if (hit || (cnt_reg == IDX_W'(SLOTS-1))) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        found_next = '0;
                        state_next = S_IDLE;
                        if (!hit) begin
                            status_next = (op_reg == OP_INSERT) ? ST_FULL : ST_MISSING;
                        end else if (op_reg == OP_INSERT) begin
                            wr_en       = 1'b1;
                            status_next = ST_STORED;
                        end else if (rd_data.valid) begin
                            status_next = ST_FOUND;
                            found_next  = rd_data.word;
                        end else begin
                            status_next = ST_MISSING;
                        end
                    end else begin
                        // hold on this slot until the previous result is taken
                        rd_addr = idx_reg;
                    end
                end else begin
                    idx_next = idx_adv;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load a new result or drop the one just taken
    assign out_valid_next = res_load || (out_valid_reg && !m_tready);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= in_fire ? '1 : cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg   <= opcode_t'(s_tuser[0]);
            key_reg  <= s_tdata[KEY_W-1:0];
            word_reg <= s_tdata[KEY_W+WORD_W-1:KEY_W];
        end
        idx_reg    <= idx_next;
        stepr_reg  <= stepr_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = found_reg;
    assign m_tuser  = status_reg;

`include "double_hash_table_macros.svh"

    `DHT_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `DHT_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "data moved")
    `DHT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_fire, !s_tready, "not busy after accept")
    `DHT_ASSERT_NOW(a_quiet_clear, aclk, aresetn, state_reg == S_CLEAR, !m_tvalid, "result in clear")

endmodule

@@ tb/sv/double_hash_table_tb.sv @@
module double_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dht_pkg::*;

    localparam int SLOTS = 16;

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] word;
    } reply_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [30:0] key, [62:31] data_word, [63] zero
    logic [0:0]  s_tuser;   // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] found_word
    logic [1:0]  m_tuser;   // [1:0] status

    // Shadow copy of the slot store, updated as each transaction is accepted
    logic              shadow_valid [SLOTS];
    logic [KEY_W-1:0]  shadow_key   [SLOTS];
    logic [WORD_W-1:0] shadow_word  [SLOTS];

    reply_t            pending_replies [$];
    logic [KEY_W-1:0]  key_pool [32];
    int                mismatch_count;
    bit                quiet_mode;

    double_hash_table #(.SLOTS(SLOTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Walk the double-hash sequence; return the stop slot or -1 when exhausted
    function automatic int find_probe_slot(input logic [KEY_W-1:0] key);
        int unsigned home;
        int unsigned step;
        int unsigned idx;
        home = key % SLOTS;
        step = 7 - (key % 7);
        for (int i = 0; i < SLOTS; i++) begin
            idx = (home + i * step) % SLOTS;
            if (!shadow_valid[idx] || shadow_key[idx] == key) begin
                return idx;
            end
        end
        return -1;
    endfunction

    // Apply one operation to the shadow store and return the reply it causes
    function automatic reply_t predict_reply(input opcode_t op, input logic [KEY_W-1:0] key,
                                             input logic [WORD_W-1:0] word);
        reply_t rep;
        int     hit;
        hit = find_probe_slot(key);
        rep.word = '0;
        if (op == OP_INSERT) begin
            if (hit < 0) begin
                rep.status = ST_FULL;
            end else begin
                shadow_valid[hit] = 1'b1;
                shadow_key[hit]   = key;
                shadow_word[hit]  = word;
                rep.status = ST_STORED;
            end
        end else begin
            if (hit >= 0 && shadow_valid[hit]) begin
                rep.status = ST_FOUND;
                rep.word   = shadow_word[hit];
            end else begin
                rep.status = ST_MISSING;
            end
        end
        return rep;
    endfunction

    // Drive one transaction and hold it until accepted; called and returns at a falling edge
    task automatic send_item(input opcode_t op, input logic [KEY_W-1:0] key,
                             input logic [WORD_W-1:0] word);
        int gap;
        gap = quiet_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, word, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(predict_reply(op, key, word));
        @(negedge aclk);
    endtask

    // Drop valid and hold until every outstanding reply has arrived
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Lookups on an empty table at the key extremes
    task automatic test_empty_lookups();
        send_item(OP_LOOKUP, '0, '1);
        send_item(OP_LOOKUP, '1, '0);
    endtask

    // Insert extremes, overwrite in place, read back
    task automatic test_insert_overwrite();
        send_item(OP_INSERT, '0, '0);
        send_item(OP_INSERT, '1, '1);
        send_item(OP_INSERT, '0, 32'hA5A5_5A5A);
        send_item(OP_LOOKUP, '0, '0);
        send_item(OP_LOOKUP, '1, '0);
    endtask

    // Occupy every even slot, then use a key with an even step: its probe revisits
    // only even slots, so the insert reports full and the lookup runs out of probes
    task automatic test_revisited_slots();
        for (int k = 2; k <= 14; k += 2) begin
            send_item(OP_INSERT, KEY_W'(k), $urandom());
        end
        send_item(OP_INSERT, KEY_W'(26), $urandom());
        send_item(OP_LOOKUP, KEY_W'(26), '0);
        send_item(OP_LOOKUP, KEY_W'(12), '0);
    endtask

    // Random inserts and lookups; pooled keys make hits, overwrites and collisions common
    task automatic test_random_traffic(input int count);
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] word;
        opcode_t           op;
        int                r;
        for (int n = 0; n < count; n++) begin
            op = opcode_t'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 70) begin
                key = key_pool[$urandom_range(0, 31)];
            end else begin
                key = KEY_W'($urandom());
            end
            r = $urandom_range(0, 19);
            word = (r == 0) ? '0 : (r == 1) ? '1 : $urandom();
            send_item(op, key, word);
        end
    endtask

    // Pause the sender until the block has answered everything, several times
    task automatic test_drain_pause();
        for (int n = 0; n < 8; n++) begin
            test_random_traffic($urandom_range(1, 6));
            wait_for_replies();
        end
    endtask

    // Stretch with no idling on either side
    task automatic test_back_to_back(input int count);
        quiet_mode = 1'b1;
        test_random_traffic(count);
        quiet_mode = 1'b0;
    endtask

    // Random backpressure on the result channel
    initial begin : result_sink
        int stall_len;
        int run_len;
        @(posedge aresetn);
        forever begin
            stall_len = quiet_mode ? 0 : pick_gap();
            run_len   = $urandom_range(1, 12);
            if (stall_len > 0) begin
                m_tready <= 1'b0;
                repeat (stall_len) @(negedge aclk);
            end
            m_tready <= 1'b1;
            repeat (run_len) @(negedge aclk);
        end
    end

    // Compare each result transaction with the oldest expected reply
    always @(posedge aclk) begin
        reply_t exp_rep;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result: status %0d found_word %h", m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                exp_rep = pending_replies.pop_front();
                if (m_tuser !== exp_rep.status) begin
                    $error("status: expected %0d, actual %0d", exp_rep.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata !== exp_rep.word) begin
                    $error("found_word: expected %h, actual %h", exp_rep.word, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop well past the slowest correct run
    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        aresetn        = 1'b0;
        mismatch_count = 0;
        quiet_mode     = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_word[i]  = '0;
        end
        // Half small keys that collide often, half full-width keys
        for (int i = 0; i < 32; i++) begin
            key_pool[i] = (i < 16) ? KEY_W'($urandom_range(0, 63)) : KEY_W'($urandom());
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_lookups();
        test_insert_overwrite();
        test_revisited_slots();
        test_random_traffic(600);
        test_drain_pause();
        test_back_to_back(200);
        test_random_traffic(370);

        wait_for_replies();
        repeat (SLOTS + 20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/dht_pkg.sv
hw/rtl/dht_mod_unit.sv
hw/rtl/dht_slot_ram.sv
hw/rtl/double_hash_table.sv
tb/sv/double_hash_table_tb.sv
